@@ sv/rgb_to_ihs_pixel_macros.svh @@
// Assertion macros for the RGB to IHS pixel converter.
// Used by the checker; expects i_clk and i_rst_n in the enclosing scope.
`ifndef RGB_TO_IHS_PIXEL_MACROS_SVH
`define RGB_TO_IHS_PIXEL_MACROS_SVH

// Condition in the same cycle implies consequence in the same cycle.
`define RIHS_ASSERT_IMPL(label, cond, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (cons)) \
        else $error("rgb_to_ihs_pixel assertion failed");

// Condition in one cycle implies consequence in the next cycle.
`define RIHS_ASSERT_NEXT(label, cond, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (cons)) \
        else $error("rgb_to_ihs_pixel assertion failed");

`endif

@@ sv/rgbihs_pkg.sv @@
// Package for the RGB to IHS pixel converter: payload types, pipeline stage type,
// fixed-point constants and the arctangent table. No dependencies.
`default_nettype none

package rgbihs_pkg;

    // Pixel as it enters the block.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // Converted pixel.
    typedef struct packed {
        logic [7:0] intensity;
        logic [7:0] hue;
        logic [7:0] saturation;
    } t_ihs;

    // Number of CORDIC iterations, one per pipeline stage.
    localparam int CORDIC_STEPS = 16;
    // Saturation divider steps, run in the first iteration stages.
    localparam int DIV_STEPS = 8;
    // Cycles from an input transfer to its result strobe.
    localparam int LATENCY = CORDIC_STEPS + 4;

    // Angles in Q16 radians.
    localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;
    localparam logic [18:0] TWO_PI_Q16 = 19'd411775;

    // State carried through the iteration stages.
    typedef struct packed {
        logic               valid;
        logic               gray;
        logic               neg;
        logic [7:0]         inten;
        logic signed [28:0] x;
        logic signed [28:0] y;
        logic signed [19:0] z;
        logic [10:0]        rem;
        logic [10:0]        den;
        logic [7:0]         quo;
        logic               full;
        logic               nz;
    } t_stage;

    // atan(2^-k) in Q16 radians, rounded to nearest.
    function automatic logic signed [19:0] atan_q16(input int k);
        logic signed [19:0] a;
        case (k)
            0:       a = 20'sd51472;
            1:       a = 20'sd30386;
            2:       a = 20'sd16055;
            3:       a = 20'sd8150;
            4:       a = 20'sd4091;
            5:       a = 20'sd2047;
            6:       a = 20'sd1024;
            7:       a = 20'sd512;
            8:       a = 20'sd256;
            9:       a = 20'sd128;
            10:      a = 20'sd64;
            11:      a = 20'sd32;
            12:      a = 20'sd16;
            13:      a = 20'sd8;
            14:      a = 20'sd4;
            15:      a = 20'sd2;
            default: a = 20'sd0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

@@ sv/rgb_to_ihs_pixel.sv @@
// Throughput: one pixel per cycle; busy is never raised.
// Latency is set by the 16 CORDIC stages of the hue angle, plus two front
// stages and two back stages. Synchronous active-low reset clears all valid
// bits; payload registers are not reset. The receiver cannot stall.
`default_nettype none

module rgb_to_ihs_pixel (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire rgbihs_pkg::t_rgb i_pix,
    output logic               o_valid,
    output rgbihs_pkg::t_ihs   o_ihs
);
    import rgbihs_pkg::*;

    localparam logic signed [28:0] SQRT3_Q16 = 29'sd113512;
    localparam logic [21:0] INV_TWO_PI_Q24 = 22'd2670177;

    // Stage one: channel sums, extremes and chroma axes.
    logic               r_s1_valid;
    logic               r_s1_gray;
    logic [7:0]         r_s1_inten;
    logic signed [10:0] r_s1_u;
    logic signed [8:0]  r_s1_v;
    logic [10:0]        r_s1_i3;
    logic [8:0]         r_s1_cmax;
    logic [8:0]         r_s1_cmin;

    logic [8:0]  n_cr, n_cg, n_cb, n_cmax, n_cmin;
    logic [10:0] n_i3;
    logic [24:0] n_iprod;

    always_comb begin
        n_cr   = {i_pix.red, 1'b1};
        n_cg   = {i_pix.green, 1'b1};
        n_cb   = {i_pix.blue, 1'b1};
        n_i3   = 11'(n_cr) + 11'(n_cg) + 11'(n_cb);
        n_cmax = (n_cr > n_cg) ? n_cr : n_cg;
        if (n_cb > n_cmax) begin
            n_cmax = n_cb;
        end
        n_cmin = (n_cr < n_cg) ? n_cr : n_cg;
        if (n_cb < n_cmin) begin
            n_cmin = n_cb;
        end
        // The sum is odd, so i3/6 is never whole and a reciprocal floor is exact.
        n_iprod = 25'(n_i3) * 25'(14'd10923);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= start & ~busy;
            r_s1_gray  <= (i_pix.red == i_pix.green) && (i_pix.red == i_pix.blue);
            r_s1_inten <= ((i_pix.red == i_pix.green) && (i_pix.red == i_pix.blue)) ?
                          i_pix.red : n_iprod[23:16];
            r_s1_u     <= $signed({2'b00, i_pix.blue, 1'b0}) - $signed({3'b000, i_pix.red})
                          - $signed({3'b000, i_pix.green});
            r_s1_v     <= $signed({1'b0, i_pix.red}) - $signed({1'b0, i_pix.green});
            r_s1_i3    <= n_i3;
            r_s1_cmax  <= n_cmax;
            r_s1_cmin  <= n_cmin;
        end
    end

    // Stage two: scaled vector, quadrant prerotation and saturation operands.
    t_stage n_s2;
    t_stage r_s2;
    logic signed [28:0] n_x0, n_y0;
    logic [19:0] n_lhs, n_rhs;
    logic [10:0] n_dmin, n_dmax, n_num, n_den;

    always_comb begin
        n_x0   = {{2{r_s1_u[10]}}, r_s1_u, 16'b0};
        n_y0   = $signed({{20{r_s1_v[8]}}, r_s1_v}) * SQRT3_Q16;
        n_dmin = r_s1_i3 - 11'(3 * r_s1_cmin);
        n_dmax = 11'(3 * r_s1_cmax) - r_s1_i3;
        n_lhs  = 20'(r_s1_i3) * 20'(r_s1_cmax - r_s1_cmin);
        n_rhs  = {n_dmin, 9'b0};
        if (n_lhs <= n_rhs) begin
            n_num = n_dmin;
            n_den = r_s1_i3;
        end else begin
            n_num = n_dmax;
            n_den = 11'd1536 - r_s1_i3;
        end

        n_s2       = '0;
        n_s2.valid = r_s1_valid;
        n_s2.gray  = r_s1_gray;
        n_s2.inten = r_s1_inten;
        n_s2.neg   = n_y0 < 29'sd0;
        n_s2.x     = n_x0;
        n_s2.y     = n_y0;
        n_s2.z     = 20'sd0;
        if (n_x0 < 29'sd0) begin
            if (n_y0 >= 29'sd0) begin
                n_s2.x = n_y0;
                n_s2.y = -n_x0;
                n_s2.z = HALF_PI_Q16;
            end else begin
                n_s2.x = -n_y0;
                n_s2.y = n_x0;
                n_s2.z = -HALF_PI_Q16;
            end
        end
        n_s2.rem  = n_num;
        n_s2.den  = n_den;
        n_s2.quo  = 8'd0;
        n_s2.full = n_num >= n_den;
        n_s2.nz   = n_num != 11'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
        end else begin
            r_s2 <= n_s2;
        end
    end

    // CORDIC and saturation divider stages.
    t_stage w_it;

    rgbihs_iter u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stg   (r_s2),
        .o_stg   (w_it)
    );

    // Back stage one: angle side fix, wrap, turn product and saturation finish.
    logic               r_b1_valid;
    logic               r_b1_gray;
    logic [7:0]         r_b1_inten;
    logic [7:0]         r_b1_sat;
    logic [40:0]        r_b1_prod;
    logic signed [19:0] n_z;
    logic [7:0]         n_sat;

    always_comb begin
        n_z = w_it.z;
        if (!w_it.neg && n_z < 20'sd0) begin
            n_z = 20'sd0;
        end
        if (w_it.neg && n_z >= 20'sd0) begin
            n_z = -20'sd1;
        end
        if (n_z < 20'sd0) begin
            n_z = n_z + $signed({1'b0, TWO_PI_Q16});
        end
        if (w_it.gray) begin
            n_sat = 8'd0;
        end else if (w_it.full) begin
            n_sat = 8'd255;
        end else if (w_it.rem == 11'd0 && w_it.nz) begin
            n_sat = w_it.quo - 8'd1;
        end else begin
            n_sat = w_it.quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid <= 1'b0;
        end else begin
            r_b1_valid <= w_it.valid;
            r_b1_gray  <= w_it.gray;
            r_b1_inten <= w_it.inten;
            r_b1_sat   <= n_sat;
            r_b1_prod  <= 41'(n_z[18:0]) * 41'(INV_TWO_PI_Q24);
        end
    end

    // Back stage two: clamp the turn and scale it to the hue code.
    logic [24:0] n_turn_w;
    logic [23:0] n_turn;
    logic [7:0]  n_hue;

    always_comb begin
        n_turn_w = r_b1_prod[40:16];
        n_turn   = n_turn_w[24] ? 24'hFFFFFF : n_turn_w[23:0];
        if (r_b1_gray) begin
            n_hue = 8'd0;
        end else if (n_turn[15:0] == 16'd0 && n_turn != 24'd0) begin
            n_hue = n_turn[23:16] - 8'd1;
        end else begin
            n_hue = n_turn[23:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid          <= r_b1_valid;
            o_ihs.intensity  <= r_b1_inten;
            o_ihs.hue        <= n_hue;
            o_ihs.saturation <= r_b1_sat;
        end
    end

    // A new pixel can be taken in every cycle.
    assign busy = 1'b0;

endmodule

`default_nettype wire

@@ sv/rgbihs_iter.sv @@
// Iteration pipeline of the RGB to IHS converter: one CORDIC vectoring step per
// stage, plus one restoring divide step for saturation in the first stages. Uses rgbihs_pkg.
`default_nettype none

module rgbihs_iter (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire rgbihs_pkg::t_stage i_stg,
    output rgbihs_pkg::t_stage     o_stg
);
    import rgbihs_pkg::*;

    t_stage w_stg [CORDIC_STEPS+1];

    assign w_stg[0] = i_stg;

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
        t_stage n_stg;
        t_stage r_stg;
        logic [11:0] w_rem2;

        // One rotation toward the x axis, with one quotient bit when due.
        always_comb begin
            n_stg  = w_stg[k];
            w_rem2 = {w_stg[k].rem, 1'b0};
            if (w_stg[k].y > 29'sd0) begin
                n_stg.x = w_stg[k].x + (w_stg[k].y >>> k);
                n_stg.y = w_stg[k].y - (w_stg[k].x >>> k);
                n_stg.z = w_stg[k].z + atan_q16(k);
            end else begin
                n_stg.x = w_stg[k].x - (w_stg[k].y >>> k);
                n_stg.y = w_stg[k].y + (w_stg[k].x >>> k);
                n_stg.z = w_stg[k].z - atan_q16(k);
            end
            if (k < DIV_STEPS) begin
                if (w_rem2 >= {1'b0, w_stg[k].den}) begin
                    n_stg.rem = 11'(w_rem2 - {1'b0, w_stg[k].den});
                    n_stg.quo = {w_stg[k].quo[6:0], 1'b1};
                end else begin
                    n_stg.rem = w_rem2[10:0];
                    n_stg.quo = {w_stg[k].quo[6:0], 1'b0};
                end
            end
        end

        // Stage register; only the valid bit is reset.
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_stg.valid <= 1'b0;
            end else begin
                r_stg <= n_stg;
            end
        end

        assign w_stg[k+1] = r_stg;
    end

    assign o_stg = w_stg[CORDIC_STEPS];

endmodule

`default_nettype wire

@@ sv/rgbihs_checker.sv @@
// Port-level checker for the RGB to IHS converter, bound to the top level.
// Uses rgbihs_pkg and rgb_to_ihs_pixel_macros.svh.
`default_nettype none

`include "rgb_to_ihs_pixel_macros.svh"

module rgbihs_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire rgbihs_pkg::t_rgb i_pix,
    input wire logic        o_valid,
    input wire rgbihs_pkg::t_ihs o_ihs
);
    import rgbihs_pkg::*;

    // The block never pushes back.
    `RIHS_ASSERT_IMPL(a_never_busy, 1'b1, !busy)

    // Every result strobe comes from a transfer a fixed latency earlier.
    `RIHS_ASSERT_IMPL(a_strobe_has_source, o_valid, $past(start, LATENCY))

    // A gray pixel comes out with zero hue and saturation and its own level.
    `RIHS_ASSERT_IMPL(a_gray_result,
        o_valid && $past(i_pix.red == i_pix.green && i_pix.red == i_pix.blue, LATENCY),
        o_ihs.hue == 8'd0 && o_ihs.saturation == 8'd0 &&
        o_ihs.intensity == $past(i_pix.red, LATENCY))

    // With no transfer behind it, the strobe stays low.
    `RIHS_ASSERT_NEXT(a_no_phantom, !$past(start, LATENCY - 1), !o_valid)

endmodule

bind rgb_to_ihs_pixel rgbihs_checker u_rgbihs_checker (.*);

`default_nettype wire

@@ tb/rgb_to_ihs_pixel_checker.sv @@
// Checker for the RGB to IHS pixel converter: predicts each converted pixel
// from the accepted input transfers and compares it with the result strobes.
// Depends on rgbihs_pkg for the payload types.
`default_nettype none

module rgb_to_ihs_pixel_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic        i_busy,
    input  wire rgbihs_pkg::t_rgb i_pix,
    input  wire logic        i_valid,
    input  wire rgbihs_pkg::t_ihs i_ihs,
    output int               o_errors,
    output int               o_pending,
    output logic             o_xfer
);
    import rgbihs_pkg::*;

    localparam longint SQRT3_Q16 = 113512;
    localparam longint HALF_PI = 102944;
    localparam longint TWO_PI = 411775;
    localparam longint INV_TWO_PI_Q24 = 2670177;
    localparam longint OUT_SCALE = 16777215;

    t_ihs expected_pixels[$];

    // Output ratio num/den scaled to 0..255.
    function automatic logic [7:0] scaled_ratio(input longint num, input longint den);
        longint q;
        if (den == 0) return 8'd0;
        q = (num * OUT_SCALE) / (den * 65536);
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    // Vectoring CORDIC on the chroma vector, angle turned into 8-bit hue.
    function automatic logic [7:0] hue_angle(input longint u, input longint v);
        longint x, y, z, t, nx, ny, turn;
        longint angles[16];
        bit neg;
        angles = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                   256, 128, 64, 32, 16, 8, 4, 2};
        x = u * 65536;
        y = v * SQRT3_Q16;
        z = 0;
        neg = (y < 0);
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = HALF_PI;
            end else begin
                t = x; x = -y; y = t; z = -HALF_PI;
            end
        end
        for (int k = 0; k < 16; k++) begin
            if (y > 0) begin
                nx = x + (y >>> k);
                ny = y - (x >>> k);
                z += angles[k];
            end else begin
                nx = x - (y >>> k);
                ny = y + (x >>> k);
                z -= angles[k];
            end
            x = nx;
            y = ny;
        end
        // Keep the angle on the correct side of zero.
        if (!neg && z < 0) z = 0;
        if (neg && z >= 0) z = -1;
        if (z < 0) z += TWO_PI;
        turn = (z * INV_TWO_PI_Q24) >>> 16;
        if (turn >= (64'sd1 << 24)) turn = (64'sd1 << 24) - 1;
        return 8'((turn * OUT_SCALE) >>> 40);
    endfunction

    function automatic t_ihs convert_pixel(input t_rgb p);
        t_ihs res;
        longint r, g, b, cr, cg, cb, cmax, cmin, i3;
        r = longint'(p.red);
        g = longint'(p.green);
        b = longint'(p.blue);
        if (r == g && r == b) begin
            res.intensity = p.red;
            res.hue = 8'd0;
            res.saturation = 8'd0;
            return res;
        end
        cr = 2 * r + 1;
        cg = 2 * g + 1;
        cb = 2 * b + 1;
        i3 = cr + cg + cb;
        cmax = (cr > cg) ? cr : cg;
        if (cb > cmax) cmax = cb;
        cmin = (cr < cg) ? cr : cg;
        if (cb < cmin) cmin = cb;
        res.intensity = scaled_ratio(i3, 1536);
        res.hue = hue_angle(2 * b - r - g, r - g);
        if (i3 * (cmax - cmin) <= 512 * (i3 - 3 * cmin))
            res.saturation = scaled_ratio(i3 - 3 * cmin, i3);
        else
            res.saturation = scaled_ratio(3 * cmax - i3, 1536 - i3);
        return res;
    endfunction

    assign o_pending = expected_pixels.size();
    assign o_xfer = i_rst_n && ((i_start && !i_busy) || i_valid);

    // Record input transfers and compare result strobes, in order.
    always @(posedge i_clk) begin
        t_ihs exp_pix;
        if (!i_rst_n) begin
            o_errors <= 0;
        end else begin
            if (i_start && !i_busy)
                expected_pixels.push_back(convert_pixel(i_pix));
            if (i_valid) begin
                if (expected_pixels.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, i_ihs);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_pix = expected_pixels.pop_front();
                    if (i_ihs.intensity !== exp_pix.intensity ||
                        i_ihs.hue !== exp_pix.hue ||
                        i_ihs.saturation !== exp_pix.saturation) begin
                        $display("%0t: mismatch expected i=%0d h=%0d s=%0d, %s=%0d h=%0d s=%0d",
                                 $time, exp_pix.intensity, exp_pix.hue, exp_pix.saturation,
                                 "actual i", i_ihs.intensity, i_ihs.hue, i_ihs.saturation);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ tb/tb_rgb_to_ihs_pixel.sv @@
// Testbench top for the RGB to IHS pixel converter: drives directed and random
// pixels with idle bursts and gives the verdict. Depends on rgbihs_pkg and the checker.
`default_nettype none

module tb_rgb_to_ihs_pixel;
    import rgbihs_pkg::*;

    localparam int N_RANDOM = 750;
    localparam int STALL_LIMIT = 2000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    t_rgb i_pix = '0;
    logic busy;
    logic o_valid;
    t_ihs o_ihs;
    int errors;
    int pending;
    logic xfer;
    int idle_cycles = 0;

    always #5 i_clk = ~i_clk;

    rgb_to_ihs_pixel uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_pix(i_pix), .o_valid(o_valid), .o_ihs(o_ihs)
    );

    rgb_to_ihs_pixel_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_pix(i_pix), .i_valid(o_valid), .i_ihs(o_ihs),
        .o_errors(errors), .o_pending(pending), .o_xfer(xfer)
    );

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        idle_cycles <= xfer ? 0 : idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("** rgb_to_ihs_pixel: FAILED **");
            $finish;
        end
    end

    // Present one pixel and hold it until the transfer.
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        start <= 1'b1;
        i_pix <= '{red: r, green: g, blue: b};
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic pause_sender(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Random pixel, often gray or with channels near each other.
    task automatic send_random(input bit with_gaps);
        logic [7:0] r, g, b;
        int mode;
        mode = $urandom_range(0, 9);
        r = 8'($urandom);
        g = 8'($urandom);
        b = 8'($urandom);
        if (mode == 0) begin
            g = r; b = r;
        end else if (mode <= 2) begin
            g = 8'(r + $urandom_range(0, 2) - 1);
            b = 8'(r + $urandom_range(0, 2) - 1);
        end else if (mode == 3) begin
            g = r;
        end
        if (with_gaps && $urandom_range(0, 7) == 0)
            pause_sender($urandom_range(1, 15));
        send_pixel(r, g, b);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, gray pixels, primaries and hues near zero.
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(8'd100, 8'd100, 8'd101);
        send_pixel(8'd100, 8'd100, 8'd99);
        send_pixel(8'd101, 8'd100, 8'd200);
        send_pixel(8'd100, 8'd101, 8'd200);
        send_pixel(8'd1, 8'd0, 8'd0);
        send_pixel(8'd254, 8'd255, 8'd255);
        send_pixel(8'd170, 8'd85, 8'd0);
        send_pixel(8'd128, 8'd127, 8'd0);
        send_pixel(8'd127, 8'd128, 8'd255);

        // Wait out every expected result once.
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);

        // Random part with idle bursts, then a stretch without gaps.
        for (int n = 0; n < N_RANDOM; n++)
            send_random(n < N_RANDOM - 100);
        start <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
        if (errors == 0)
            $display("** rgb_to_ihs_pixel: PASSED **");
        else
            $display("** rgb_to_ihs_pixel: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
